// ===== sv/psz_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package psz_pkg;

  localparam int FRAME_WIDTH  = 512;
  localparam int FRAME_HEIGHT = 256;
  localparam int MAX_SPLAT    = 4;
  localparam int PIX_COUNT    = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W       = $clog2(PIX_COUNT);

  localparam int MEM_W        = 64;
  localparam int IN_TDATA_W   = 152;
  localparam int OUT_TDATA_W  = 64;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 48;

  localparam logic [31:0] Z_NEAR      = 32'd3277;
  localparam logic [31:0] Z_FAR_BIAS  = 32'd1966080;
  localparam logic [31:0] DEPTH_EMPTY = 32'hFFFF_FFFF;
  localparam logic [31:0] DEPTH_MAX   = 32'hFFFF_FFFE;

  localparam logic [CFG_IDX_W-1:0] CFG_ROT0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd5;

  typedef enum logic [1:0] {
    REQ_DRAW  = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NOP   = 2'd3
  } req_e;

endpackage
`default_nettype wire

// ===== sv/psz_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module psz_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== sv/point_splat_zbuffer_render.sv =====
// Draw: rotation runs nine products through one shared multiplier, each projection axis
//   takes two partial products and a 68-step divider, and each in-frame splat pixel takes
//   a read and then a depth-tested write on the store, which has one read and one write port.
// Clear: one store word per cycle. Read: the stored word is registered, then loaded into the output.
// Reset (async, active low) restores the control and configuration registers and starts a
//   sweep over all PIX_COUNT words that empties the store; no item is taken until it ends.
`timescale 1ns / 1ps
`default_nettype none
module point_splat_zbuffer_render
  import psz_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // pos_x, pos_y, pos_z, point_color, pixel_x, pixel_y, zero fill
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // req_type
  input  wire logic [1:0]             s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // pixel_color, pixel_depth
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam logic [3:0] ST_CLR     = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_ROT_MUL = 4'd2;
  localparam logic [3:0] ST_ROT_ACC = 4'd3;
  localparam logic [3:0] ST_CHK     = 4'd4;
  localparam logic [3:0] ST_MUL_LO  = 4'd5;
  localparam logic [3:0] ST_MUL_HI  = 4'd6;
  localparam logic [3:0] ST_SUM     = 4'd7;
  localparam logic [3:0] ST_DIV     = 4'd8;
  localparam logic [3:0] ST_OFF     = 4'd9;
  localparam logic [3:0] ST_SCR     = 4'd10;
  localparam logic [3:0] ST_PIX_RD  = 4'd11;
  localparam logic [3:0] ST_PIX_WR  = 4'd12;
  localparam logic [3:0] ST_RD_WAIT = 4'd13;
  localparam logic [3:0] ST_RD_OUT  = 4'd14;

  localparam logic signed [42:0] BASE_X = 43'(FRAME_WIDTH * 32768);
  localparam logic signed [42:0] BASE_Y = 43'(FRAME_HEIGHT * 32768);
  localparam logic [40:0] OFF_LIMIT = 41'h100_0000_0000;

  logic [3:0]  state_q, state_d;
  logic [ADDR_W-1:0] clr_addr_q;
  logic [31:0] clr_color_q;
  logic [47:0] rot_q [3];
  logic [31:0] cam_q, focal_q;
  logic [2:0]  rad_cfg_q;
  logic        out_valid_q;
  logic [OUT_TDATA_W-1:0] out_q;

  logic signed [31:0] px_q [3];
  logic [31:0] color_q;
  logic [1:0]  row_q, col_q;
  logic signed [49:0] acc_q;
  logic signed [65:0] prod_q;
  logic signed [35:0] v_q [3];
  logic [35:0] z_q;
  logic        axis_q;
  logic [63:0] pp_lo_q;
  logic [67:0] num_q;
  logic [35:0] rem_q;
  logic [6:0]  div_cnt_q;
  logic signed [26:0] sx_q, sy_q;
  logic [2:0]  rad_q;
  logic [31:0] depth_q;
  logic signed [3:0] dx_q, dy_q;
  logic [OUT_TDATA_W-1:0] res_q;

  logic in_acc;
  req_e req;
  logic [8:0] in_px;
  logic [7:0] in_py;
  logic rd_in_frame;
  logic [ADDR_W-1:0] rd_addr;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign req    = req_e'(s_axis_tuser);
  assign in_px  = s_axis_tdata[136:128];
  assign in_py  = s_axis_tdata[144:137];
  assign rd_in_frame = (int'(in_px) < FRAME_WIDTH) && (int'(in_py) < FRAME_HEIGHT);
  assign rd_addr = ADDR_W'(ADDR_W'(in_py) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(in_px));

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [35:0] v_sel, mag;
  logic v_neg;
  logic [15:0] entry;

  assign v_sel = axis_q ? v_q[1] : v_q[0];
  assign v_neg = v_sel < 0;
  assign mag   = v_neg ? -v_sel : v_sel;
  assign entry = rot_q[row_q][16*col_q +: 16];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_ROT_MUL: begin
        mul_a = 33'(signed'(entry));
        mul_b = 33'(px_q[col_q]);
      end
      ST_MUL_LO: begin
        mul_a = signed'({1'b0, mag[31:0]});
        mul_b = signed'({1'b0, focal_q});
      end
      ST_MUL_HI: begin
        mul_a = signed'({29'd0, mag[35:32]});
        mul_b = signed'({1'b0, focal_q});
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // rotation accumulate and truncation toward zero
  logic signed [49:0] acc_sum, acc_adj;
  assign acc_sum = acc_q + 50'(prod_q);
  assign acc_adj = acc_sum + ((acc_sum < 0) ? 50'sd16383 : 50'sd0);

  // near/far test
  logic signed [36:0] z_full, z_far;
  logic z_drop;
  assign z_full = 37'(v_q[2]) + signed'({5'd0, cam_q});
  assign z_far  = signed'({3'd0, cam_q, 2'b00}) + signed'({5'd0, Z_FAR_BIAS});
  assign z_drop = (z_full < signed'({5'd0, Z_NEAR})) || (z_full > z_far);

  // divider step
  logic [36:0] rem_sh;
  logic        div_ge;
  assign rem_sh = {rem_q, num_q[67]};
  assign div_ge = rem_sh >= {1'b0, z_q};

  // offset to screen coordinate
  logic [40:0] off_mag;
  logic signed [42:0] off_s, scr_s, scr_adj;
  logic signed [26:0] scr;
  assign off_mag = (|num_q[67:40]) ? OFF_LIMIT : num_q[40:0];
  assign off_s   = v_neg ? -signed'({2'b00, off_mag}) : signed'({2'b00, off_mag});
  assign scr_s   = axis_q ? (BASE_Y - off_s) : (BASE_X + off_s);
  assign scr_adj = scr_s + ((scr_s < 0) ? 43'sd65535 : 43'sd0);
  assign scr     = 27'(scr_adj >>> 16);

  // splat window
  logic [2:0] rad_eff;
  logic signed [27:0] rad_s, sx_e, sy_e;
  logic scr_drop;
  assign rad_eff = (int'(rad_cfg_q) > MAX_SPLAT) ? 3'(MAX_SPLAT) : rad_cfg_q;
  assign rad_s   = signed'({25'd0, rad_eff});
  assign sx_e    = 28'(sx_q);
  assign sy_e    = 28'(sy_q);
  assign scr_drop = (sx_e < -rad_s) || (sx_e >= signed'(28'(FRAME_WIDTH)) + rad_s) ||
                    (sy_e < -rad_s) || (sy_e >= signed'(28'(FRAME_HEIGHT)) + rad_s);

  logic signed [26:0] xx, yy;
  logic pix_in, pix_last, dx_last;
  logic [ADDR_W-1:0] pix_addr;
  logic signed [3:0] rad4;
  assign rad4  = signed'({1'b0, rad_q});
  assign xx    = sx_q + 27'(dx_q);
  assign yy    = sy_q + 27'(dy_q);
  assign pix_in = (xx >= 0) && (xx < signed'(27'(FRAME_WIDTH))) &&
                  (yy >= 0) && (yy < signed'(27'(FRAME_HEIGHT)));
  assign pix_addr = ADDR_W'(ADDR_W'(yy) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(xx));
  assign dx_last  = dx_q == rad4;
  assign pix_last = dx_last && (dy_q == rad4);

  // store
  logic ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [MEM_W-1:0] ram_wdata, ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pix_addr;
    ram_wdata = {depth_q, color_q};
    ram_re    = 1'b0;
    ram_raddr = pix_addr;
    case (state_q)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
        ram_wdata = {DEPTH_EMPTY, clr_color_q};
      end
      ST_IDLE: begin
        ram_re    = in_acc && (req == REQ_READ) && rd_in_frame;
        ram_raddr = rd_addr;
      end
      ST_PIX_RD: ram_re = pix_in;
      ST_PIX_WR: ram_we = depth_q < ram_rdata[63:32];
      default: ;
    endcase
  end

  psz_ram #(
    .Width(MEM_W),
    .Depth(PIX_COUNT)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  logic out_load;
  assign out_load = (state_q == ST_RD_OUT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLR: if (int'(clr_addr_q) == PIX_COUNT - 1) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          case (req)
            REQ_DRAW:  state_d = ST_ROT_MUL;
            REQ_CLEAR: state_d = ST_CLR;
            REQ_READ:  state_d = rd_in_frame ? ST_RD_WAIT : ST_RD_OUT;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_ROT_MUL: state_d = ST_ROT_ACC;
      ST_ROT_ACC: begin
        if (col_q == 2'd2 && row_q == 2'd2) begin
          state_d = ST_CHK;
        end else begin
          state_d = ST_ROT_MUL;
        end
      end
      ST_CHK:    state_d = z_drop ? ST_IDLE : ST_MUL_LO;
      ST_MUL_LO: state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_SUM;
      ST_SUM:    state_d = ST_DIV;
      ST_DIV:    if (div_cnt_q == 7'd1) state_d = ST_OFF;
      ST_OFF:    state_d = axis_q ? ST_SCR : ST_MUL_LO;
      ST_SCR:    state_d = scr_drop ? ST_IDLE : ST_PIX_RD;
      ST_PIX_RD: begin
        if (pix_in) begin
          state_d = ST_PIX_WR;
        end else if (pix_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_PIX_WR:  state_d = pix_last ? ST_IDLE : ST_PIX_RD;
      ST_RD_WAIT: state_d = ST_RD_OUT;
      ST_RD_OUT:  if (out_load) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_addr_q  <= '0;
      clr_color_q <= '0;
      rot_q[0]    <= 48'd16384;
      rot_q[1]    <= 48'd16384 << 16;
      rot_q[2]    <= 48'd16384 << 32;
      cam_q       <= 32'd327680;
      focal_q     <= 32'd14529626;
      rad_cfg_q   <= 3'd1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLR) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      if (state_q == ST_IDLE && in_acc && req == REQ_CLEAR) begin
        clr_addr_q  <= '0;
        clr_color_q <= s_axis_tdata[127:96];
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROT0:   rot_q[0]  <= cfg_data_i;
          CFG_ROT1:   rot_q[1]  <= cfg_data_i;
          CFG_ROT2:   rot_q[2]  <= cfg_data_i;
          CFG_CAM:    cam_q     <= cfg_data_i[31:0];
          CFG_FOCAL:  focal_q   <= cfg_data_i[31:0];
          CFG_RADIUS: rad_cfg_q <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        px_q[0] <= s_axis_tdata[31:0];
        px_q[1] <= s_axis_tdata[63:32];
        px_q[2] <= s_axis_tdata[95:64];
        color_q <= s_axis_tdata[127:96];
        row_q   <= '0;
        col_q   <= '0;
        acc_q   <= '0;
        axis_q  <= 1'b0;
        res_q   <= {DEPTH_EMPTY, 32'd0};
      end
      ST_ROT_MUL: prod_q <= mul_p;
      ST_ROT_ACC: begin
        if (col_q == 2'd2) begin
          v_q[row_q] <= 36'(acc_adj >>> 14);
          acc_q      <= '0;
          col_q      <= '0;
          row_q      <= row_q + 1'b1;
        end else begin
          acc_q <= acc_sum;
          col_q <= col_q + 1'b1;
        end
      end
      ST_CHK:    z_q <= 36'(z_full);
      ST_MUL_LO: prod_q <= mul_p;
      ST_MUL_HI: begin
        pp_lo_q <= prod_q[63:0];
        prod_q  <= mul_p;
      end
      ST_SUM: begin
        num_q     <= {4'd0, pp_lo_q} + {prod_q[35:0], 32'd0};
        rem_q     <= '0;
        div_cnt_q <= 7'd68;
      end
      ST_DIV: begin
        rem_q     <= div_ge ? 36'(rem_sh - {1'b0, z_q}) : 36'(rem_sh);
        num_q     <= {num_q[66:0], div_ge};
        div_cnt_q <= div_cnt_q - 1'b1;
      end
      ST_OFF: begin
        if (axis_q) begin
          sy_q <= scr;
        end else begin
          sx_q <= scr;
        end
        axis_q <= 1'b1;
      end
      ST_SCR: begin
        rad_q   <= rad_eff;
        depth_q <= (z_q > {4'd0, DEPTH_MAX}) ? DEPTH_MAX : z_q[31:0];
        dx_q    <= -signed'({1'b0, rad_eff});
        dy_q    <= -signed'({1'b0, rad_eff});
      end
      ST_PIX_RD, ST_PIX_WR: begin
        // advance unless a read was just issued
        if (state_q == ST_PIX_WR || !pix_in) begin
          if (dx_last) begin
            dx_q <= -rad4;
            dy_q <= dy_q + 1'b1;
          end else begin
            dx_q <= dx_q + 1'b1;
          end
        end
      end
      ST_RD_WAIT: res_q <= ram_rdata;
      default: ;
    endcase
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule
`default_nettype wire

// ===== sv/psz_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
module psz_chk
  import psz_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic [1:0]             s_axis_tuser,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  a_draw_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && s_axis_tuser == REQ_DRAW |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("draw item did not hold off input");

  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && s_axis_tuser == REQ_CLEAR |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("clear item did not hold off input");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && s_axis_tuser == REQ_READ |=> !s_axis_tready)
    else $error("read item did not hold off input");

endmodule

bind point_splat_zbuffer_render psz_chk u_psz_chk (.*);
`default_nettype wire
